// ----- rtl/tked_pkg.sv -----
// Shared codes and byte constants for the terminal key escape decoder.
package tked_pkg;

  typedef enum logic [3:0] {
    EV_INSERT = 4'd0,
    EV_BACK   = 4'd1,
    EV_TAB    = 4'd2,
    EV_ENTER  = 4'd3,
    EV_UP     = 4'd4,
    EV_DOWN   = 4'd5,
    EV_RIGHT  = 4'd6,
    EV_LEFT   = 4'd7,
    EV_DELETE = 4'd8,
    EV_HOME   = 4'd9,
    EV_END    = 4'd10
  } key_event_t;

  localparam logic [7:0] KB_BS       = 8'd8;
  localparam logic [7:0] KB_TAB      = 8'd9;
  localparam logic [7:0] KB_LF       = 8'd10;
  localparam logic [7:0] KB_ESC      = 8'd27;
  localparam logic [7:0] KB_DEL      = 8'd127;
  localparam logic [7:0] KB_DEL_HI   = 8'd247;
  localparam logic [7:0] KB_LBRACKET = 8'h5B;
  localparam logic [7:0] KB_O        = 8'h4F;
  localparam logic [7:0] KB_A        = 8'h41;
  localparam logic [7:0] KB_B        = 8'h42;
  localparam logic [7:0] KB_C        = 8'h43;
  localparam logic [7:0] KB_D        = 8'h44;
  localparam logic [7:0] KB_H        = 8'h48;
  localparam logic [7:0] KB_F        = 8'h46;
  localparam logic [7:0] KB_1        = 8'h31;
  localparam logic [7:0] KB_3        = 8'h33;
  localparam logic [7:0] KB_4        = 8'h34;
  localparam logic [7:0] KB_5        = 8'h35;
  localparam logic [7:0] KB_6        = 8'h36;
  localparam logic [7:0] KB_TILDE    = 8'h7E;
  localparam logic [7:0] KB_SEMI     = 8'h3B;

endpackage

// ----- rtl/terminal_key_escape_decoder_core.sv -----
// Terminal key escape decoder: byte stream in, key event transactions out.
//
//   channel | ports                                   | direction
//   in      | in_valid, in_ready, in_key_byte         | byte from terminal
//   out     | out_valid, out_ready, out_key_event,    | decoded key event
//           | out_char_code                           |
//
// One byte accepted per cycle while in_ready is high; its event (if any) appears
// on out the next cycle. Parser state advances in the cycle a byte is accepted.
// Reset returns the parser to idle and empties the result register.
// in_ready drops only while a result waits and out_ready is low.
module terminal_key_escape_decoder_core
  import tked_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_key_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_key_event,
  output logic [7:0] out_char_code
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_ESC    = 4'd1,
    ST_CSI    = 4'd2,
    ST_SS3    = 4'd3,
    ST_DEL    = 4'd4,
    ST_HOME1  = 4'd5,
    ST_END4   = 4'd6,
    ST_PAGE   = 4'd7,
    ST_MOD    = 4'd8,
    ST_MODEND = 4'd9
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  key_event_t event_r, event_nxt;
  logic [7:0] char_r, char_nxt;
  key_event_t dec_event;
  logic       dec_hit;
  logic       in_fire;

  assign in_ready      = !out_valid_r || out_ready;
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_key_event = event_r;
  assign out_char_code = char_r;

  always_comb begin
    state_nxt = ST_IDLE;
    dec_event = EV_INSERT;
    dec_hit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        case (in_key_byte) inside
          KB_BS, KB_DEL, KB_DEL_HI: begin
            dec_event = EV_BACK;
            dec_hit   = 1'b1;
          end
          KB_TAB: begin
            dec_event = EV_TAB;
            dec_hit   = 1'b1;
          end
          KB_LF: begin
            dec_event = EV_ENTER;
            dec_hit   = 1'b1;
          end
          KB_ESC: state_nxt = ST_ESC;
          default: begin
            dec_event = EV_INSERT;
            dec_hit   = 1'b1;
          end
        endcase
      end
      ST_ESC: begin
        if (in_key_byte == KB_LBRACKET) state_nxt = ST_CSI;
        else if (in_key_byte == KB_O) state_nxt = ST_SS3;
      end
      ST_CSI: begin
        case (in_key_byte) inside
          KB_A: begin dec_event = EV_UP;    dec_hit = 1'b1; end
          KB_B: begin dec_event = EV_DOWN;  dec_hit = 1'b1; end
          KB_C: begin dec_event = EV_RIGHT; dec_hit = 1'b1; end
          KB_D: begin dec_event = EV_LEFT;  dec_hit = 1'b1; end
          KB_H: begin dec_event = EV_HOME;  dec_hit = 1'b1; end
          KB_F: begin dec_event = EV_END;   dec_hit = 1'b1; end
          KB_3: state_nxt = ST_DEL;
          KB_1: state_nxt = ST_HOME1;
          KB_4: state_nxt = ST_END4;
          KB_5, KB_6: state_nxt = ST_PAGE;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SS3: begin
        if (in_key_byte == KB_H) begin
          dec_event = EV_HOME;
          dec_hit   = 1'b1;
        end else if (in_key_byte == KB_F) begin
          dec_event = EV_END;
          dec_hit   = 1'b1;
        end
      end
      ST_DEL: begin
        if (in_key_byte == KB_TILDE) begin
          dec_event = EV_DELETE;
          dec_hit   = 1'b1;
        end else if (in_key_byte == KB_SEMI) begin
          state_nxt = ST_MOD;
        end
      end
      ST_HOME1: begin
        if (in_key_byte == KB_TILDE) begin
          dec_event = EV_HOME;
          dec_hit   = 1'b1;
        end else if (in_key_byte == KB_SEMI) begin
          state_nxt = ST_MOD;
        end
      end
      ST_END4: begin
        if (in_key_byte == KB_TILDE) begin
          dec_event = EV_END;
          dec_hit   = 1'b1;
        end
      end
      ST_PAGE: begin
        if (in_key_byte == KB_SEMI) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        case (in_key_byte) inside
          KB_3, KB_5, KB_A, KB_B, KB_C, KB_D: state_nxt = ST_MODEND;
          default: state_nxt = ST_IDLE;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    event_nxt     = event_r;
    char_nxt      = char_r;
    if (in_fire && dec_hit) begin
      out_valid_nxt = 1'b1;
      event_nxt     = dec_event;
      char_nxt      = (dec_event == EV_INSERT) ? in_key_byte : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    event_r <= event_nxt;
    char_r  <= char_nxt;
  end

  // Non-insert events carry a zero char code.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (event_r != EV_INSERT) |-> char_r == 8'd0)
    else $error("char code set on non-insert event");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> event_r <= EV_END)
    else $error("event code out of range");

  a_esc_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (state_r == ST_IDLE) && (in_key_byte == KB_ESC)
      |=> (state_r == ST_ESC) && !out_valid_r)
    else $error("escape byte did not start a sequence");

  a_seq_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && dec_hit |=> state_r == ST_IDLE && out_valid_r)
    else $error("event did not return parser to idle");

endmodule
